// ===== design/dri_pkg.sv =====
// Shared widths, types and constants for the dead-reckoning double integrator.
// No dependencies.
package dri_pkg;

    localparam int ACCEL_WIDTH    = 16;
    localparam int FRAC_BITS      = 8;
    localparam int VELOCITY_WIDTH = 40;
    localparam int POS_WIDTH      = 32;
    localparam int LIMIT_WIDTH    = 8;

    // position is integrated in units of 2^-SHIFT_K
    localparam int SHIFT_K   = FRAC_BITS + 2;
    localparam int SUM_WIDTH = ((POS_WIDTH + SHIFT_K > VELOCITY_WIDTH + 1) ?
                                (POS_WIDTH + SHIFT_K) : (VELOCITY_WIDTH + 1)) + 1;
    localparam int QUOT_WIDTH = SUM_WIDTH - SHIFT_K;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(25);

    typedef logic signed [ACCEL_WIDTH-1:0]    t_accel;
    typedef logic signed [VELOCITY_WIDTH-1:0] t_vel;
    typedef logic signed [POS_WIDTH-1:0]      t_pos;
    typedef logic [LIMIT_WIDTH-1:0]           t_limit;

    typedef struct packed {
        logic   en;
        t_limit limit;
    } t_axis_ctrl;

endpackage

// ===== design/dri_axis.sv =====
// One axis: holds previous sample, velocity, position and zero-run count,
// and computes the next position combinationally. Depends on dri_pkg.
module dri_axis
    import dri_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_axis_ctrl i_ctrl,
    input  t_accel     i_accel,
    output t_pos       o_pos_next
);

    t_accel         r_prev;
    t_vel           r_vel;
    t_pos           r_pos;
    t_limit         r_run;

    logic signed [ACCEL_WIDTH:0]    delta;
    logic signed [VELOCITY_WIDTH:0] v_sum;
    t_vel                           v_new;
    t_vel                           n_vel;
    logic signed [SUM_WIDTH-1:0]    total;
    logic signed [QUOT_WIDTH-1:0]   quot;
    logic                           round_up;
    logic [QUOT_WIDTH-POS_WIDTH:0]  top_bits;
    t_limit                         n_run;

    always_comb begin
        delta = {r_prev[ACCEL_WIDTH-1], r_prev} + {i_accel[ACCEL_WIDTH-1], i_accel};
        v_sum = {r_vel[VELOCITY_WIDTH-1], r_vel}
              + {{(VELOCITY_WIDTH-ACCEL_WIDTH){delta[ACCEL_WIDTH]}}, delta};
        if (v_sum[VELOCITY_WIDTH] != v_sum[VELOCITY_WIDTH-1]) begin
            v_new = v_sum[VELOCITY_WIDTH] ? {1'b1, {(VELOCITY_WIDTH-1){1'b0}}}
                                          : {1'b0, {(VELOCITY_WIDTH-1){1'b1}}};
        end else begin
            v_new = v_sum[VELOCITY_WIDTH-1:0];
        end

        total = {{(SUM_WIDTH-POS_WIDTH-SHIFT_K){r_pos[POS_WIDTH-1]}}, r_pos,
                 {SHIFT_K{1'b0}}}
              + {{(SUM_WIDTH-VELOCITY_WIDTH){r_vel[VELOCITY_WIDTH-1]}}, r_vel}
              + {{(SUM_WIDTH-VELOCITY_WIDTH){v_new[VELOCITY_WIDTH-1]}}, v_new};

        // truncate toward zero
        round_up = total[SUM_WIDTH-1] && (total[SHIFT_K-1:0] != '0);
        quot     = total[SUM_WIDTH-1:SHIFT_K] + QUOT_WIDTH'(round_up);
        top_bits = quot[QUOT_WIDTH-1:POS_WIDTH-1];
        if (top_bits == '0 || top_bits == '1) begin
            o_pos_next = quot[POS_WIDTH-1:0];
        end else begin
            o_pos_next = quot[QUOT_WIDTH-1] ? {1'b1, {(POS_WIDTH-1){1'b0}}}
                                            : {1'b0, {(POS_WIDTH-1){1'b1}}};
        end

        if (i_accel == '0) begin
            n_run = (r_run < i_ctrl.limit) ? r_run + 1'b1 : r_run;
        end else begin
            n_run = '0;
        end
        n_vel = (n_run >= i_ctrl.limit) ? '0 : v_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_vel  <= '0;
            r_pos  <= '0;
            r_run  <= '0;
        end else if (i_ctrl.en) begin
            r_prev <= i_accel;
            r_vel  <= n_vel;
            r_pos  <= o_pos_next;
            r_run  <= n_run;
        end
    end

endmodule

// ===== design/dead_reckoning_double_integrator.sv =====
// Top level: input register, three axis integrators, result register.
// Depends on dri_pkg and dri_axis.
//
//  channel  | signals                               | dir
//  ---------+---------------------------------------+-----
//  input    | i_valid o_ready i_accel_x/y/z         | in
//  result   | o_valid i_ready o_pos_x/y/z           | out
//  config   | i_cfg_we i_cfg_data (zero_count_limit)| in
//
// An accepted item passes through the input register, then the result register;
// one item per cycle sustained while the result side does not stall, with the
// per-axis state update (add, shift, saturate) done combinationally.
// The input register keeps accepting while a result waits, until both hold items.
// Synchronous active-low reset clears all axis state; limit resets to 25.
module dead_reckoning_double_integrator
    import dri_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_accel i_accel_x,
    input  t_accel i_accel_y,
    input  t_accel i_accel_z,
    output logic   o_valid,
    input  logic   i_ready,
    output t_pos   o_pos_x,
    output t_pos   o_pos_y,
    output t_pos   o_pos_z,
    input  logic   i_cfg_we,
    input  t_limit i_cfg_data
);

    logic       r_in_valid;
    t_accel     r_ax, r_ay, r_az;
    logic       r_out_valid;
    t_pos       r_px, r_py, r_pz;
    t_limit     r_limit;
    logic       advance;
    t_axis_ctrl ctrl;
    t_pos       pos_x, pos_y, pos_z;

    assign advance   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || advance;
    assign ctrl.en    = advance;
    assign ctrl.limit = r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
        end
    end

    dri_axis u_axis_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .i_accel(r_ax), .o_pos_next(pos_x)
    );
    dri_axis u_axis_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .i_accel(r_ay), .o_pos_next(pos_y)
    );
    dri_axis u_axis_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .i_accel(r_az), .o_pos_next(pos_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_px <= pos_x;
            r_py <= pos_y;
            r_pz <= pos_z;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pos_x = r_px;
    assign o_pos_y = r_py;
    assign o_pos_z = r_pz;

endmodule

// ===== design/dri_checker.sv =====
// Port-level checks for dead_reckoning_double_integrator, bound to the top.
// Depends on dri_pkg.
module dri_assert_checker
    import dri_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_valid,
    input logic   o_ready,
    input logic   o_valid,
    input logic   i_ready,
    input t_pos   o_pos_x,
    input t_pos   o_pos_y,
    input t_pos   o_pos_z
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("not empty after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_pos_x) && $stable(o_pos_y) && $stable(o_pos_z)))
        else $error("stalled result changed");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with no result pending");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready && o_ready && i_valid) |=> (i_ready || !o_ready))
        else $error("item accepted with both registers full");

endmodule

bind dead_reckoning_double_integrator dri_assert_checker u_dri_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready),
    .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z)
);

// ===== tb/dri_checker.sv =====
// Scoreboard for the dead-reckoning double integrator: watches the input, result and
// config ports, predicts the three positions per item and compares them in order.
// Depends on dri_pkg.
module dri_checker
    import dri_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_ready,
    input  t_accel i_accel_x,
    input  t_accel i_accel_y,
    input  t_accel i_accel_z,
    input  logic   i_out_valid,
    input  logic   i_out_ready,
    input  t_pos   i_pos_x,
    input  t_pos   i_pos_y,
    input  t_pos   i_pos_z,
    input  logic   i_cfg_we,
    input  t_limit i_cfg_data,
    output int     o_errors,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_pos x;
        t_pos y;
        t_pos z;
    } t_pos_set;

    t_accel   last_accel [3];
    t_vel     axis_vel   [3];
    t_pos     axis_pos   [3];
    t_limit   zero_streak[3];
    t_limit   clear_limit;
    t_pos_set pos_q[$];
    int       err_cnt;
    int       n_pending;

    assign o_errors  = err_cnt;
    assign o_pending = n_pending;

    // one trapezoid step on one axis; returns the new integer position
    function automatic t_pos integrate_axis(input int ax, input t_accel a);
        longint vmax, vmin, v_old, v_new, scaled, p;
        vmax   = (longint'(1) << (VELOCITY_WIDTH - 1)) - 1;
        vmin   = -vmax - 1;
        v_old  = longint'(axis_vel[ax]);
        v_new  = v_old + longint'(last_accel[ax]) + longint'(a);
        if (v_new > vmax) begin
            v_new = vmax;
        end else if (v_new < vmin) begin
            v_new = vmin;
        end
        // exact sum in units of 2^-SHIFT_K, then divide truncating toward zero
        scaled = (longint'(axis_pos[ax]) <<< SHIFT_K) + v_old + v_new;
        p      = scaled / (longint'(1) << SHIFT_K);
        if (p > longint'(32'sh7FFF_FFFF)) begin
            p = longint'(32'sh7FFF_FFFF);
        end else if (p < -longint'(32'sh7FFF_FFFF) - 1) begin
            p = -longint'(32'sh7FFF_FFFF) - 1;
        end
        axis_pos[ax]   = t_pos'(p);
        axis_vel[ax]   = t_vel'(v_new);
        last_accel[ax] = a;
        if (a == 0) begin
            if (zero_streak[ax] < clear_limit) begin
                zero_streak[ax] = zero_streak[ax] + 1'b1;
            end
        end else begin
            zero_streak[ax] = '0;
        end
        if (zero_streak[ax] >= clear_limit) begin
            axis_vel[ax] = '0;
        end
        return axis_pos[ax];
    endfunction

    task automatic check_pos(input string name, input t_pos exp_v, input t_pos act_v);
        if (exp_v !== act_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_pos_set exp_set;
        if (!i_rst_n) begin
            for (int ax = 0; ax < 3; ax++) begin
                last_accel[ax]  = '0;
                axis_vel[ax]    = '0;
                axis_pos[ax]    = '0;
                zero_streak[ax] = '0;
            end
            clear_limit = LIMIT_RESET;
            pos_q.delete();
            err_cnt   = 0;
            n_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                clear_limit = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (pos_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, got %0d %0d %0d",
                             $time, i_pos_x, i_pos_y, i_pos_z);
                end else begin
                    exp_set = pos_q.pop_front();
                    check_pos("pos_x", exp_set.x, i_pos_x);
                    check_pos("pos_y", exp_set.y, i_pos_y);
                    check_pos("pos_z", exp_set.z, i_pos_z);
                end
            end
            if (i_in_valid && i_in_ready) begin
                exp_set.x = integrate_axis(0, i_accel_x);
                exp_set.y = integrate_axis(1, i_accel_y);
                exp_set.z = integrate_axis(2, i_accel_z);
                pos_q.push_back(exp_set);
            end
            n_pending <= pos_q.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the integrator testbench: clock, reset, sample stimulus, result-side stalls
// and config writes; the verdict comes from dri_checker's failure and pending counts.
// Depends on dri_pkg, dri_checker and dead_reckoning_double_integrator.
module testbench;
    import dri_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic   i_clk      = 1'b0;
    logic   i_rst_n    = 1'b0;
    logic   i_valid    = 1'b0;
    logic   i_ready    = 1'b0;
    t_accel i_accel_x  = '0;
    t_accel i_accel_y  = '0;
    t_accel i_accel_z  = '0;
    logic   i_cfg_we   = 1'b0;
    t_limit i_cfg_data = '0;
    logic   o_ready;
    logic   o_valid;
    t_pos   o_pos_x;
    t_pos   o_pos_y;
    t_pos   o_pos_z;
    int     chk_errors;
    int     chk_pending;

    int     idle_pct = 0;
    logic   hold_req = 1'b0;
    int     zero_left[3] = '{0, 0, 0};

    dead_reckoning_double_integrator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_pos_x    (o_pos_x),
        .o_pos_y    (o_pos_y),
        .o_pos_z    (o_pos_z),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    dri_checker u_dri_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_pos_x     (o_pos_x),
        .i_pos_y     (o_pos_y),
        .i_pos_z     (o_pos_z),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // result-side stalls, plus one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input t_accel ax, input t_accel ay, input t_accel az);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_accel_x <= ax;
        i_accel_y <= ay;
        i_accel_z <= az;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input t_limit lim);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic t_accel rand_accel();
        case ($urandom_range(0, 7))
            0:       return t_accel'(32767);
            1:       return t_accel'(-32768);
            2, 3:    return t_accel'(int'($urandom_range(0, 31)) - 16);
            default: return t_accel'($urandom);
        endcase
    endfunction

    // zero runs of random length so that velocity clearing is reached often
    function automatic t_accel axis_sample(input int ax);
        if (zero_left[ax] > 0) begin
            zero_left[ax]--;
            return '0;
        end
        if ($urandom_range(0, 15) == 0) begin
            zero_left[ax] = $urandom_range(1, 40);
            return '0;
        end
        return rand_accel();
    endfunction

    initial begin
        t_limit phase_lim[5];
        t_accel ax, ay, az;
        phase_lim = '{3, 255, 4, 0, 1};
        phase_lim[3] = t_limit'($urandom_range(2, 40));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and bit patterns under the reset limit
        send_item(32767, -32768, 0);
        send_item(32767, -32768, 0);
        send_item(-32768, 32767, 1);
        send_item(-1, 1, -1);
        send_item(16'h5555, 16'hAAAA, 16'h00FF);
        send_item(16'hAAAA, 16'h5555, 16'hFF00);
        send_item(1, -1, 256);
        drain();

        // short limit: clear after two zeros
        write_limit(2);
        repeat (4) send_item(0, 0, 0);
        send_item(100, -100, 0);
        send_item(0, 0, 0);
        drain();

        // limit of zero: every item clears
        write_limit(0);
        send_item(500, -500, 32767);
        send_item(32767, 0, -32768);
        send_item(0, 0, 0);
        drain();

        write_limit(255);
        send_item(-32768, -32768, -32768);
        send_item(1, 2, 3);
        drain();

        // random phases
        for (int ph = 0; ph < 5; ph++) begin
            idle_pct = (ph == 2) ? 0 : $urandom_range(5, 40);
            write_limit(phase_lim[ph]);
            for (int n = 0; n < 200; n++) begin
                if (ph == 1 && n == 50) begin
                    hold_req = 1'b1;
                end
                ax = axis_sample(0);
                ay = axis_sample(1);
                az = axis_sample(2);
                send_item(ax, ay, az);
            end
            // leave long zero runs so the next, lower limit clears at once
            if (ph == 1) begin
                repeat (12) send_item(0, 0, 0);
            end
            drain();
        end

        // last part, no idling: drive x and y hard one way and back
        idle_pct = 0;
        write_limit(1);
        repeat (2) send_item(0, 0, 0);
        for (int n = 0; n < 60; n++) begin
            send_item(32767, -32768, rand_accel());
        end
        repeat (2) send_item(0, 0, rand_accel());
        for (int n = 0; n < 30; n++) begin
            send_item(-32768, 32767, rand_accel());
        end
        drain();
        repeat (8) @(posedge i_clk);

        if (chk_errors == 0 && chk_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/dri_pkg.sv
design/dri_axis.sv
design/dead_reckoning_double_integrator.sv
design/dri_checker.sv
tb/dri_checker.sv
tb/testbench.sv
